// File: design/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// shared types, constants and helpers of the circle canvas rasteriser
// ----------------------------------------------------------------------------
`default_nettype none

package ccr_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int SIDE_W    = $clog2(MAX_SIDE);
  localparam int ADDR_W    = 2 * SIDE_W;
  localparam int DIM_W     = 9;
  localparam int FRAC_BITS = 8;

  localparam int COORD_W   = 20;
  localparam int RAD_W     = 19;
  localparam int CHAR_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  localparam int POS_W     = SIDE_W + FRAC_BITS;
  localparam int DIFF_W    = ((POS_W > COORD_W) ? POS_W : COORD_W) + 2;
  localparam int MAG_W     = DIFF_W - 1;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int DIST_W    = SQ_W + 1;
  localparam int R2_W      = 2 * RAD_W;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CIRCLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic [BYTE_W-1:0] KIND_OUTLINE = 8'h63;
  localparam logic [BYTE_W-1:0] KIND_FILLED  = 8'h43;
  localparam logic [BYTE_W-1:0] BORDER_LOW   = 8'd33;
  localparam logic [BYTE_W-1:0] BORDER_HIGH  = 8'd126;

  localparam logic [CHAR_W-1:0] BACKGROUND_RESET = 7'd32;
  localparam logic [DIM_W-1:0]  DIM_RESET        = 9'd1;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 2'd2;

  typedef struct packed {
    logic                     start;
    logic                     clear_mode;
    logic                     filled;
    logic [SIDE_W:0]          width;
    logic [SIDE_W:0]          height;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]         radius;
    logic [CHAR_W-1:0]        paint;
  } sweep_cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } ram_wr_t;

  function automatic logic [SIDE_W:0] side_of(input logic [DIM_W-1:0] v);
    logic [SIDE_W:0] s;
    s = (SIDE_W + 1)'(MAX_SIDE);
    if (v == '0) begin
      s = (SIDE_W + 1)'(1);
    end else if (v <= DIM_W'(MAX_SIDE)) begin
      s = v[SIDE_W:0];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/ccr_canvas_ram.sv
// ----------------------------------------------------------------------------
// ccr_canvas_ram
// canvas store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_canvas_ram (
  input  wire                         clk,
  input  wire ccr_pkg::ram_wr_t       wr,
  input  wire [ccr_pkg::ADDR_W-1:0]   rd_addr,
  output logic [ccr_pkg::CHAR_W-1:0]  rd_data
);

  logic [ccr_pkg::CHAR_W-1:0] mem [2**ccr_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: design/ccr_sweep.sv
// ----------------------------------------------------------------------------
// ccr_sweep
// cell sweep for clear and circle: raster counters and a squared-distance
// pipeline (p1, p2, p3) that decides the canvas write for each cell
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_sweep (
  input  wire                      clk,
  input  wire                      rst,
  input  wire ccr_pkg::sweep_cmd_t cmd,
  output logic                     busy,
  output ccr_pkg::ram_wr_t         wr
);

  localparam int SW = ccr_pkg::SIDE_W;

  logic                              running;
  logic [SW-1:0]                     col;
  logic [SW-1:0]                     row;
  logic                              clear_mode;
  logic                              filled;
  logic [SW:0]                       width;
  logic [SW:0]                       height;
  logic signed [ccr_pkg::COORD_W-1:0] cx;
  logic signed [ccr_pkg::COORD_W-1:0] cy;
  logic [ccr_pkg::RAD_W-1:0]         rad;
  logic [ccr_pkg::RAD_W-1:0]         rad_m1;
  logic                              thin;
  logic [ccr_pkg::CHAR_W-1:0]        paint;
  logic [ccr_pkg::R2_W-1:0]          r2;
  logic [ccr_pkg::R2_W-1:0]          rin2;

  logic                              p1_valid;
  logic [ccr_pkg::ADDR_W-1:0]        p1_addr;
  logic [ccr_pkg::MAG_W-1:0]         p1_adx;
  logic [ccr_pkg::MAG_W-1:0]         p1_ady;
  logic                              p2_valid;
  logic [ccr_pkg::ADDR_W-1:0]        p2_addr;
  logic [ccr_pkg::SQ_W-1:0]          p2_dx2;
  logic [ccr_pkg::SQ_W-1:0]          p2_dy2;
  logic                              p3_valid;
  logic [ccr_pkg::ADDR_W-1:0]        p3_addr;
  logic [ccr_pkg::DIST_W-1:0]        p3_d2;

  logic                              last_col;
  logic                              last_row;
  logic signed [ccr_pkg::DIFF_W-1:0] dx;
  logic signed [ccr_pkg::DIFF_W-1:0] dy;
  logic [ccr_pkg::DIFF_W-1:0]        adx;
  logic [ccr_pkg::DIFF_W-1:0]        ady;
  logic                              in_circle;
  logic                              edge_band;

  assign last_col = ({1'b0, col} == width - (SW + 1)'(1));
  assign last_row = ({1'b0, row} == height - (SW + 1)'(1));

  // distance from the scaled cell position to the centre
  assign dx = $signed(ccr_pkg::DIFF_W'({col, {ccr_pkg::FRAC_BITS{1'b0}}}))
            - ccr_pkg::DIFF_W'(cx);
  assign dy = $signed(ccr_pkg::DIFF_W'({row, {ccr_pkg::FRAC_BITS{1'b0}}}))
            - ccr_pkg::DIFF_W'(cy);
  assign adx = dx[ccr_pkg::DIFF_W-1] ? ccr_pkg::DIFF_W'(-dx) : ccr_pkg::DIFF_W'(dx);
  assign ady = dy[ccr_pkg::DIFF_W-1] ? ccr_pkg::DIFF_W'(-dy) : ccr_pkg::DIFF_W'(dy);

  assign in_circle = p3_d2 <= ccr_pkg::DIST_W'(r2);
  assign edge_band = thin || (p3_d2 > ccr_pkg::DIST_W'(rin2));

  assign busy = running || p1_valid || p2_valid || p3_valid;

  always_comb begin
    wr.we   = p3_valid && (clear_mode || (in_circle && (filled || edge_band)));
    wr.addr = p3_addr;
    wr.data = paint;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      col      <= '0;
      row      <= '0;
    end else begin
      p1_valid <= running;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      if (cmd.start) begin
        running <= 1'b1;
        col     <= '0;
        row     <= '0;
      end else if (running) begin
        if (last_col) begin
          col <= '0;
          if (last_row) begin
            running <= 1'b0;
            row     <= '0;
          end else begin
            row <= row + SW'(1);
          end
        end else begin
          col <= col + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      clear_mode <= cmd.clear_mode;
      filled     <= cmd.filled;
      width      <= cmd.width;
      height     <= cmd.height;
      cx         <= cmd.center_x;
      cy         <= cmd.center_y;
      rad        <= cmd.radius;
      rad_m1     <= cmd.radius - ccr_pkg::RAD_W'(1 << ccr_pkg::FRAC_BITS);
      thin       <= (cmd.radius[ccr_pkg::RAD_W-1:ccr_pkg::FRAC_BITS] == '0);
      paint      <= cmd.paint;
    end
    r2      <= rad * rad;
    rin2    <= rad_m1 * rad_m1;
    p1_addr <= {row, col};
    p1_adx  <= adx[ccr_pkg::MAG_W-1:0];
    p1_ady  <= ady[ccr_pkg::MAG_W-1:0];
    p2_addr <= p1_addr;
    p2_dx2  <= p1_adx * p1_adx;
    p2_dy2  <= p1_ady * p1_ady;
    p3_addr <= p2_addr;
    p3_d2   <= ccr_pkg::DIST_W'(p2_dx2) + ccr_pkg::DIST_W'(p2_dy2);
  end

endmodule

`default_nettype wire

// File: design/circle_canvas_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_canvas_rasterizer
// character canvas with clear, circle draw and cell read commands
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one command transaction: tuser is the command (clear,
//   circle, read), tdata carries the circle and read fields
//   m_* channel returns one result transaction per command: tdata holds
//   cell_char, tuser holds status; apb port sets canvas_width, canvas_height
//   and background_char; user writes them only while idle, block has no check
// sequencing
//   clear and accepted circle: raster sweep of width * height cells
//   (one cell per cycle through the distance pipeline into the canvas ram)
//   then pipeline drain and result hand-off
//   read: one ram read; rejected circle, unused command: straight to finish
//   one command is in flight at a time; s_tready is high only while idle
// reset
//   registers return to width 1, height 1, background 32; the canvas content
//   is undefined until a clear
// stall
//   a result waits in the output register while m_tready is low; the next
//   command is still accepted and its result waits until the register frees
// ----------------------------------------------------------------------------
`default_nettype none

module circle_canvas_rasterizer (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // center_x[19:0], center_y[39:20], radius[58:40], shape_kind[66:59],
  // border_char[74:67], read_col[82:75], read_row[90:83], zero pad above
  input  wire  [95:0] s_tdata,
  // command[1:0]
  input  wire  [1:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // cell_char[6:0], zero pad [7]
  output logic [7:0]  m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_FINISH
  } state_t;

  state_t                          state;
  logic [ccr_pkg::DIM_W-1:0]       canvas_width;
  logic [ccr_pkg::DIM_W-1:0]       canvas_height;
  logic [ccr_pkg::CHAR_W-1:0]      background_char;
  logic [ccr_pkg::CHAR_W-1:0]      res_cell;
  logic [ccr_pkg::STATUS_W-1:0]    res_status;

  logic signed [ccr_pkg::COORD_W-1:0] center_x;
  logic signed [ccr_pkg::COORD_W-1:0] center_y;
  logic [ccr_pkg::RAD_W-1:0]       radius;
  logic [ccr_pkg::BYTE_W-1:0]      shape_kind;
  logic [ccr_pkg::BYTE_W-1:0]      border_char;
  logic [ccr_pkg::SIDE_W-1:0]      read_col;
  logic [ccr_pkg::SIDE_W-1:0]      read_row;
  logic [ccr_pkg::CMD_W-1:0]       command;

  logic [ccr_pkg::SIDE_W:0]        side_w;
  logic [ccr_pkg::SIDE_W:0]        side_h;
  logic                            accept;
  logic                            circle_ok;
  logic                            read_outside;
  logic                            cfg_write;
  logic [ccr_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                            sweep_busy;
  logic [ccr_pkg::CHAR_W-1:0]      rd_data;
  ccr_pkg::sweep_cmd_t             sweep_cmd;
  ccr_pkg::ram_wr_t                ram_wr;

  assign center_x    = s_tdata[19:0];
  assign center_y    = s_tdata[39:20];
  assign radius      = s_tdata[58:40];
  assign shape_kind  = s_tdata[66:59];
  assign border_char = s_tdata[74:67];
  assign read_col    = s_tdata[82:75];
  assign read_row    = s_tdata[90:83];
  assign command     = s_tuser;

  assign side_w = ccr_pkg::side_of(canvas_width);
  assign side_h = ccr_pkg::side_of(canvas_height);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign circle_ok = (radius != '0)
                  && (shape_kind == ccr_pkg::KIND_OUTLINE
                      || shape_kind == ccr_pkg::KIND_FILLED)
                  && (border_char >= ccr_pkg::BORDER_LOW)
                  && (border_char <= ccr_pkg::BORDER_HIGH);

  assign read_outside = ({1'b0, read_col} >= side_w) || ({1'b0, read_row} >= side_h);

  always_comb begin
    sweep_cmd.start      = accept && ((command == ccr_pkg::CMD_CLEAR)
                           || (command == ccr_pkg::CMD_CIRCLE && circle_ok));
    sweep_cmd.clear_mode = (command == ccr_pkg::CMD_CLEAR);
    sweep_cmd.filled     = (shape_kind == ccr_pkg::KIND_FILLED);
    sweep_cmd.width      = side_w;
    sweep_cmd.height     = side_h;
    sweep_cmd.center_x   = center_x;
    sweep_cmd.center_y   = center_y;
    sweep_cmd.radius     = radius;
    sweep_cmd.paint      = (command == ccr_pkg::CMD_CLEAR) ? background_char
                                                           : border_char[ccr_pkg::CHAR_W-1:0];
  end

  ccr_sweep u_sweep (
    .clk  (clk),
    .rst  (rst),
    .cmd  (sweep_cmd),
    .busy (sweep_busy),
    .wr   (ram_wr)
  );

  ccr_canvas_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr ({read_row, read_col}),
    .rd_data (rd_data)
  );

  // apb register file
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      ccr_pkg::REG_WIDTH:      prdata = 32'(canvas_width);
      ccr_pkg::REG_HEIGHT:     prdata = 32'(canvas_height);
      ccr_pkg::REG_BACKGROUND: prdata = 32'(background_char);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= ccr_pkg::DIM_RESET;
      canvas_height   <= ccr_pkg::DIM_RESET;
      background_char <= ccr_pkg::BACKGROUND_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        ccr_pkg::REG_WIDTH:      canvas_width    <= pwdata[ccr_pkg::DIM_W-1:0];
        ccr_pkg::REG_HEIGHT:     canvas_height   <= pwdata[ccr_pkg::DIM_W-1:0];
        ccr_pkg::REG_BACKGROUND: background_char <= pwdata[ccr_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // command sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_cell <= '0;
            case (command)
              ccr_pkg::CMD_CLEAR: begin
                res_status <= ccr_pkg::STATUS_DONE;
                state      <= ST_SWEEP;
              end
              ccr_pkg::CMD_CIRCLE: begin
                if (circle_ok) begin
                  res_status <= ccr_pkg::STATUS_DONE;
                  state      <= ST_SWEEP;
                end else begin
                  res_status <= ccr_pkg::STATUS_REJECT;
                  state      <= ST_FINISH;
                end
              end
              ccr_pkg::CMD_READ: begin
                if (read_outside) begin
                  res_status <= ccr_pkg::STATUS_OUTSIDE;
                  state      <= ST_FINISH;
                end else begin
                  res_status <= ccr_pkg::STATUS_DONE;
                  state      <= ST_READ;
                end
              end
              default: begin
                res_status <= ccr_pkg::STATUS_DONE;
                state      <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (!sweep_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_READ: begin
          res_cell <= rd_data;
          state    <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {1'b0, res_cell};
            m_tuser  <= res_status;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_sweep_in_sweep_state: assert property (@(posedge clk) disable iff (rst)
    sweep_busy |-> state == ST_SWEEP)
    else $error("sweep active outside sweep state");

  a_status_zero_cell: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ccr_pkg::STATUS_DONE) |-> m_tdata == '0)
    else $error("error status with nonzero cell");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINISH)
    else $error("result loaded outside finish state");

  a_read_path: assert property (@(posedge clk) disable iff (rst)
    (accept && command == ccr_pkg::CMD_READ) |=> (state == ST_READ || state == ST_FINISH))
    else $error("read command took wrong path");

endmodule

`default_nettype wire
